>>> rtl/poc_pkg.sv
// shared types, sizes and helpers for the order crossover core
package poc_pkg;

   localparam int GENE_COUNT  = 16;
   localparam int GENE_W      = 4;
   localparam int GENE_VALUES = 2 ** GENE_W;
   localparam int WORD_W      = 64;
   localparam int CUT_W       = 5;
   localparam int STAGES      = 4;
   localparam int RANK_W      = $clog2(2 * GENE_COUNT);

   typedef struct packed {
      logic [WORD_W-1:0] parent_a;
      logic [WORD_W-1:0] parent_b;
      logic [CUT_W-1:0]  cut_length;
   } poc_req_type;

   typedef struct packed {
      logic [WORD_W-1:0] child_a;
      logic [WORD_W-1:0] child_b;
   } poc_rsp_type;

   typedef struct packed {
      logic [STAGES-1:0] load;
      logic [STAGES-1:0] valid;
   } poc_ctrl_type;

   // cut saturates at the gene count
   function automatic logic [CUT_W-1:0] sat_cut(input logic [CUT_W-1:0] cut);
      logic [CUT_W-1:0] res;
      res = (cut > CUT_W'(GENE_COUNT)) ? CUT_W'(GENE_COUNT) : cut;
      return res;
   endfunction

endpackage

>>> rtl/poc_ctrl.sv
// valid bits and stage advance logic of the crossover pipeline
module poc_ctrl import poc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output poc_ctrl_type ctrl
);

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] adv;
   logic [STAGES-1:0] shifted;

   // a stage moves when it is empty or the one after it moves
   always_comb begin
      adv[STAGES-1] = !valid_ff[STAGES-1] || !rsp_stall;
      for (int k = STAGES - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
      shifted = {valid_ff[STAGES-2:0], req_valid};
      for (int k = 0; k < STAGES; k++) begin
         valid_in[k] = adv[k] ? shifted[k] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall  = !adv[0];
   assign rsp_valid  = valid_ff[STAGES-1];
   assign ctrl.load  = adv;
   assign ctrl.valid = valid_ff;

endmodule

>>> rtl/poc_lane.sv
// four-stage datapath that builds one child from its own and the other parent
module poc_lane import poc_pkg::*; (
   input  logic              clock,
   input  poc_ctrl_type      ctrl,
   input  logic [WORD_W-1:0] own,
   input  logic [WORD_W-1:0] other,
   input  logic [CUT_W-1:0]  cut,
   output logic [WORD_W-1:0] child
);

   // stage 1: kept prefix and the set of genes it holds
   logic [CUT_W-1:0]       cut_sat;
   logic [GENE_VALUES-1:0] seen_in;
   logic [WORD_W-1:0]      prefix_in;
   logic [GENE_VALUES-1:0] seen_s1_ff;
   logic [WORD_W-1:0]      prefix_s1_ff;
   logic [WORD_W-1:0]      other_s1_ff;
   logic [CUT_W-1:0]       cut_s1_ff;

   always_comb begin
      logic [GENE_W-1:0] g;
      cut_sat   = sat_cut(cut);
      seen_in   = '0;
      prefix_in = '0;
      g         = '0;
      for (int i = 0; i < GENE_COUNT; i++) begin
         if (CUT_W'(i) < cut_sat) begin
            g = own[i*GENE_W +: GENE_W];
            prefix_in[i*GENE_W +: GENE_W] = g;
            seen_in[g] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         seen_s1_ff   <= seen_in;
         prefix_s1_ff <= prefix_in;
         other_s1_ff  <= other;
         cut_s1_ff    <= cut_sat;
      end
   end

   // stage 2: genes of the other parent that the fill places
   logic [GENE_COUNT-1:0] keep_in;
   logic [GENE_COUNT-1:0] keep_s2_ff;
   logic [WORD_W-1:0]     prefix_s2_ff;
   logic [WORD_W-1:0]     other_s2_ff;
   logic [CUT_W-1:0]      cut_s2_ff;

   always_comb begin
      logic [GENE_W-1:0] g;
      logic              dup;
      g   = '0;
      dup = 1'b0;
      for (int j = 0; j < GENE_COUNT; j++) begin
         g   = other_s1_ff[j*GENE_W +: GENE_W];
         dup = 1'b0;
         for (int k = 0; k < GENE_COUNT; k++) begin
            if (k < j && other_s1_ff[k*GENE_W +: GENE_W] == g) begin
               dup = 1'b1;
            end
         end
         keep_in[j] = !seen_s1_ff[g] && !dup;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[1]) begin
         keep_s2_ff   <= keep_in;
         prefix_s2_ff <= prefix_s1_ff;
         other_s2_ff  <= other_s1_ff;
         cut_s2_ff    <= cut_s1_ff;
      end
   end

   // stage 3: target position of each placed gene
   logic [RANK_W-1:0]     rank_in    [GENE_COUNT];
   logic [RANK_W-1:0]     rank_s3_ff [GENE_COUNT];
   logic [GENE_COUNT-1:0] keep_s3_ff;
   logic [WORD_W-1:0]     prefix_s3_ff;
   logic [WORD_W-1:0]     other_s3_ff;

   always_comb begin
      logic [GENE_COUNT-1:0] lower;
      lower = '0;
      for (int j = 0; j < GENE_COUNT; j++) begin
         for (int k = 0; k < GENE_COUNT; k++) begin
            lower[k] = (k < j);
         end
         rank_in[j] = RANK_W'(cut_s2_ff) + RANK_W'($countones(keep_s2_ff & lower));
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[2]) begin
         rank_s3_ff   <= rank_in;
         keep_s3_ff   <= keep_s2_ff;
         prefix_s3_ff <= prefix_s2_ff;
         other_s3_ff  <= other_s2_ff;
      end
   end

   // stage 4: scatter placed genes behind the prefix
   logic [WORD_W-1:0] child_in;
   logic [WORD_W-1:0] child_ff;

   always_comb begin
      child_in = prefix_s3_ff;
      for (int p = 0; p < GENE_COUNT; p++) begin
         for (int j = 0; j < GENE_COUNT; j++) begin
            if (keep_s3_ff[j] && rank_s3_ff[j] == RANK_W'(p)) begin
               child_in[p*GENE_W +: GENE_W] = child_in[p*GENE_W +: GENE_W]
                                            | other_s3_ff[j*GENE_W +: GENE_W];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[3]) begin
         child_ff <= child_in;
      end
   end

   assign child = child_ff;

endmodule

>>> rtl/permutation_order_crossover_core.sv
// top level of the one-point order crossover core
//
// req channel: one item carries both parents (16 genes of 4 bits, gene 0 in
// the low bits) and a cut length; taken at an edge with req_valid high and
// req_stall low
// rsp channel: one item carries child_a and child_b; taken at an edge with
// rsp_valid high and rsp_stall low
// child a keeps the first cut genes of parent a, then the genes of parent b
// it does not yet hold, in parent b order; child b the same with parents
// swapped; a cut above the gene count saturates, unreachable slots read 0
// an accepted item passes through the four register stages in order (prefix and
// gene set, fill selection, position ranking, scatter) before rsp_valid rises
// throughput: one item per cycle while rsp_stall is low
// a stalled result holds in the last stage; empty stages ahead of it still
// fill, and req_stall rises only once every stage holds an item
// reset (synchronous, active high) empties the pipeline, no results pending
module permutation_order_crossover_core import poc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  poc_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output poc_rsp_type rsp_data
);

   poc_ctrl_type ctrl;

   // stage control, shared by both lanes so they stay in lock step
   poc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctrl      (ctrl)
   );

   // child a: own parent a, filled from parent b
   poc_lane u_lane_a (
      .clock (clock),
      .ctrl  (ctrl),
      .own   (req_data.parent_a),
      .other (req_data.parent_b),
      .cut   (req_data.cut_length),
      .child (rsp_data.child_a)
   );

   // child b: own parent b, filled from parent a
   poc_lane u_lane_b (
      .clock (clock),
      .ctrl  (ctrl),
      .own   (req_data.parent_b),
      .other (req_data.parent_a),
      .cut   (req_data.cut_length),
      .child (rsp_data.child_b)
   );

   // input is held off only when every stage is occupied
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&ctrl.valid))
      else $error("req_stall with an empty pipeline stage");

   // an accepted item reaches the output when rsp_stall stays low behind it
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall
      |=> rsp_valid)
      else $error("item did not arrive at the output in time");

   // a non-zero cut always keeps gene 0 of the own parent
   a_first_gene: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.cut_length != '0)
      ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall
      |=> rsp_data.child_a[GENE_W-1:0] == $past(req_data.parent_a[GENE_W-1:0], 4)
       && rsp_data.child_b[GENE_W-1:0] == $past(req_data.parent_b[GENE_W-1:0], 4))
      else $error("leading gene not kept from own parent");

endmodule

>>> sim/tb_permutation_order_crossover_core.sv
// testbench for the one-point order crossover core, self-checking against its own crossover predictor
`timescale 1ns / 1ps

module tb_permutation_order_crossover_core;
   import poc_pkg::*;

   // parents whose genes run up and down the positions
   localparam logic [WORD_W-1:0] ASCENDING  = 64'hFEDC_BA98_7654_3210;
   localparam logic [WORD_W-1:0] DESCENDING = 64'h0123_4567_89AB_CDEF;
   localparam logic [WORD_W-1:0] ALL_ZERO   = '0;
   localparam logic [WORD_W-1:0] ALL_ONES   = '1;
   // long receiver hold-off, well beyond the pipeline depth
   localparam int HOLD_CYCLES = 80;
   // settling time after the last expected pair, derived from the four pipeline stages
   localparam int SETTLE_CYCLES = 2 * STAGES + 4;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   poc_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   poc_rsp_type rsp_data;

   // idling percentages for the current phase, per cycle
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;

   // long hold-off of the receiver, counted in its own process
   logic holding = 1'b0;
   event hold_start;

   int          mismatch_count = 0;
   poc_rsp_type children_due[$];

   permutation_order_crossover_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // one child: kept prefix of its own parent, then the donor's missing genes in donor order
   function automatic logic [WORD_W-1:0] order_fill(input logic [WORD_W-1:0] own,
                                                    input logic [WORD_W-1:0] donor,
                                                    input logic [CUT_W-1:0] cut);
      logic [15:0]       held;
      logic [WORD_W-1:0] child;
      logic [GENE_W-1:0] gene;
      int                keep;
      int                slot;
      // cut saturates at the gene count, a zero cut keeps nothing
      keep  = (int'(cut) > GENE_COUNT) ? GENE_COUNT : int'(cut);
      held  = '0;
      child = '0;
      for (int i = 0; i < keep; i++) begin
         gene = own[GENE_W*i +: GENE_W];
         child[GENE_W*i +: GENE_W] = gene;
         held[gene] = 1'b1;
      end
      // repeated gene values are placed once, slots the fill never reaches stay zero
      slot = keep;
      for (int i = 0; i < GENE_COUNT; i++) begin
         gene = donor[GENE_W*i +: GENE_W];
         if (slot < GENE_COUNT && !held[gene]) begin
            child[GENE_W*slot +: GENE_W] = gene;
            held[gene] = 1'b1;
            slot++;
         end
      end
      return child;
   endfunction

   function automatic poc_rsp_type predict_children(input poc_req_type item);
      poc_rsp_type pair;
      pair.child_a = order_fill(item.parent_a, item.parent_b, item.cut_length);
      pair.child_b = order_fill(item.parent_b, item.parent_a, item.cut_length);
      return pair;
   endfunction

   // random permutation of the gene values, shuffled in place
   function automatic logic [WORD_W-1:0] shuffled_genes();
      logic [GENE_W-1:0] genes [GENE_COUNT];
      logic [GENE_W-1:0] swap;
      logic [WORD_W-1:0] word;
      int                j;
      for (int i = 0; i < GENE_COUNT; i++) genes[i] = GENE_W'(i);
      for (int i = GENE_COUNT - 1; i > 0; i--) begin
         j        = $urandom_range(i);
         swap     = genes[i];
         genes[i] = genes[j];
         genes[j] = swap;
      end
      word = '0;
      for (int i = 0; i < GENE_COUNT; i++) word[GENE_W*i +: GENE_W] = genes[i];
      return word;
   endfunction

   // overwrite a few genes so that some value repeats and another goes missing
   function automatic logic [WORD_W-1:0] with_repeats(input logic [WORD_W-1:0] word);
      logic [WORD_W-1:0] bent;
      int                pos;
      bent = word;
      repeat ($urandom_range(4, 1)) begin
         pos = $urandom_range(GENE_COUNT - 1);
         bent[GENE_W*pos +: GENE_W] = GENE_W'($urandom);
      end
      return bent;
   endfunction

   // offer one parent pair, idling first if the phase asks for it, and
   // record the expected children once the item is taken
   task automatic offer_parents(input logic [WORD_W-1:0] pa, input logic [WORD_W-1:0] pb,
                                input logic [CUT_W-1:0] cut);
      poc_req_type item;
      int          gap;
      item.parent_a   = pa;
      item.parent_b   = pb;
      item.cut_length = cut;
      gap = 0;
      while ($urandom_range(99) < sender_idle_pct) gap++;
      // valid only drops when a gap follows, so it never toggles within one step
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      children_due.push_back(predict_children(item));
   endtask

   // extremes of the fields and each special case, no idling
   task automatic test_directed();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      offer_parents(ASCENDING, DESCENDING, CUT_W'(1));
      offer_parents(ASCENDING, DESCENDING, CUT_W'(GENE_COUNT));
      offer_parents(DESCENDING, ASCENDING, CUT_W'(8));
      offer_parents(ASCENDING, DESCENDING, CUT_W'(GENE_COUNT - 1));
      offer_parents(64'h7654_3210_FEDC_BA98, DESCENDING, CUT_W'(9));
      // zero cut: children are the other parent's distinct genes
      offer_parents(ASCENDING, DESCENDING, CUT_W'(0));
      offer_parents(64'h7654_3210_FEDC_BA98, 64'h0011_2233_4455_6677, CUT_W'(0));
      // cut above the gene count saturates, up to the widest cut
      offer_parents(ASCENDING, DESCENDING, CUT_W'(GENE_COUNT + 1));
      offer_parents(DESCENDING, ASCENDING, '1);
      offer_parents(shuffled_genes(), shuffled_genes(), CUT_W'(24));
      // identical parents
      offer_parents(ASCENDING, ASCENDING, CUT_W'(5));
      // parents that are not permutations, unreachable slots read zero
      offer_parents(ALL_ZERO, ALL_ZERO, CUT_W'(1));
      offer_parents(ALL_ONES, ALL_ONES, CUT_W'(3));
      offer_parents(ALL_ONES, ALL_ZERO, CUT_W'(GENE_COUNT));
      offer_parents(ALL_ZERO, ALL_ONES, CUT_W'(0));
      offer_parents(ALL_ONES, ASCENDING, CUT_W'(2));
      // repeat inside the kept prefix is copied as it stands
      offer_parents(64'hFEDC_BA98_7654_3300, DESCENDING, CUT_W'(4));
      offer_parents(shuffled_genes(), shuffled_genes(), CUT_W'(15));
      offer_parents({$urandom, $urandom}, {$urandom, $urandom}, CUT_W'(2));
      offer_parents({$urandom, $urandom}, {$urandom, $urandom}, CUT_W'(12));
   endtask

   // mostly well-formed permutation pairs, some with repeats, some raw noise
   task automatic test_random_phase(input int idle_pct, input int stall_pct, input int count);
      logic [WORD_W-1:0] pa;
      logic [WORD_W-1:0] pb;
      logic [CUT_W-1:0]  cut;
      int                kind;
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      for (int n = 0; n < count; n++) begin
         kind = $urandom_range(99);
         pa   = shuffled_genes();
         pb   = shuffled_genes();
         cut  = CUT_W'($urandom_range(GENE_COUNT, 1));
         if (kind >= 90) begin
            // any word and any cut the field can carry
            pa  = {$urandom, $urandom};
            pb  = {$urandom, $urandom};
            cut = CUT_W'($urandom);
         end else if (kind >= 78) begin
            pa = (kind[0]) ? with_repeats(pa) : pa;
            pb = (kind[1] || !kind[0]) ? with_repeats(pb) : pb;
         end
         offer_parents(pa, pb, cut);
      end
   endtask

   // receiver holds off while items keep coming, so every stage fills and
   // the input stalls until the hold-off ends
   task automatic test_input_backpressure();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      -> hold_start;
      repeat (30) offer_parents(shuffled_genes(), shuffled_genes(),
                                CUT_W'($urandom_range(GENE_COUNT, 1)));
   endtask

   initial forever begin
      @(hold_start);
      holding <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      holding <= 1'b0;
   end

   // receiver stall, random per cycle or held off
   always @(posedge clock) begin
      rsp_stall <= holding || ($urandom_range(99) < receiver_stall_pct);
   end

   // compare every taken child pair with the oldest expectation
   always @(posedge clock) begin
      poc_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (children_due.size() == 0) begin
            mismatch_count++;
            $display("%0t: child pair with none expected, expected nothing, actual a=%h b=%h",
                     $time, rsp_data.child_a, rsp_data.child_b);
         end else begin
            want = children_due.pop_front();
            if (rsp_data.child_a !== want.child_a) begin
               mismatch_count++;
               $display("%0t: child_a expected %h actual %h",
                        $time, want.child_a, rsp_data.child_a);
            end
            if (rsp_data.child_b !== want.child_b) begin
               mismatch_count++;
               $display("%0t: child_b expected %h actual %h",
                        $time, want.child_b, rsp_data.child_b);
            end
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_phase(0, 0, 330);
      test_random_phase(63, 0, 330);
      test_random_phase(0, 63, 330);
      test_input_backpressure();
      test_random_phase(28, 28, 330);

      req_valid <= 1'b0;
      while (children_due.size() != 0) @(posedge clock);
      // any late or extra pair shows up here
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && children_due.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

>>> files.f
rtl/poc_pkg.sv
rtl/poc_ctrl.sv
rtl/poc_lane.sv
rtl/permutation_order_crossover_core.sv
sim/tb_permutation_order_crossover_core.sv
